// ===== design/abkf_pkg.sv =====
`default_nettype none
package abkf_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 24;
  localparam int unsigned DivSteps  = DataWidth + FracBits;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  typedef logic signed [DataWidth-1:0] data_t;

  // Configuration register indexes.
  localparam logic [1:0] RegStepTime     = 2'd0;
  localparam logic [1:0] RegAngleNoise   = 2'd1;
  localparam logic [1:0] RegBiasNoise    = 2'd2;
  localparam logic [1:0] RegMeasureNoise = 2'd3;

  // Operand selects for the shared multiplier.
  typedef enum logic [3:0] {
    MulRateDt,   // (rate - bias) * dt
    MulD00Dt,
    MulD01Dt,
    MulQbDt,
    MulK0Err,
    MulK1Err,
    MulK0Paa,
    MulK0Pab,
    MulK1Paa,
    MulK1Pab
  } mul_sel_e;

  // Controller states.
  typedef enum logic [4:0] {
    StIdle,
    StPredA,    // angle product
    StPredAW,   // angle update, d00 product
    StPredP0,   // cov_aa update, d01 product
    StPredP1,   // cov_ab, cov_ba update, qb product
    StPredP2,   // cov_bb update
    StDiv0Go,
    StDiv0,
    StDiv1Go,
    StDiv1,
    StCorA,     // k0*err
    StCorAW,
    StCorB,
    StCorBW,
    StCov0,
    StCov0W,
    StCov1,
    StCov1W,
    StCov2,
    StCov2W,
    StCov3,
    StCov3W,
    StOut
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     wr_angle_pred;
    logic     wr_paa_pred;
    logic     wr_pab_pred;
    logic     wr_pbb_pred;
    logic     div_start;
    logic     div_num_ba;
    logic     wr_k0;
    logic     wr_k1;
    logic     wr_angle_cor;
    logic     wr_bias_cor;
    logic     wr_paa_cor;
    logic     wr_pab_cor;
    logic     wr_pba_cor;
    logic     wr_pbb_cor;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_done;
  } stat_t;

  localparam data_t DataMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t DataMin = {1'b1, {(DataWidth-1){1'b0}}};

  // Saturating add and subtract.
  function automatic data_t add_sat(data_t a, data_t b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      add_sat = s[DataWidth] ? DataMin : DataMax;
    end else begin
      add_sat = s[DataWidth-1:0];
    end
  endfunction

  function automatic data_t sub_sat(data_t a, data_t b);
    logic signed [DataWidth:0] s;
    s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      sub_sat = s[DataWidth] ? DataMin : DataMax;
    end else begin
      sub_sat = s[DataWidth-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/abkf_datapath.sv =====
`default_nettype none
module abkf_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire abkf_pkg::cmd_t                 cmd_i,
  output abkf_pkg::stat_t                     stat_o,
  input  wire logic signed [31:0]             rate_sample_i,
  input  wire logic signed [31:0]             angle_measure_i,
  input  wire logic [24:0]                    step_time_i,
  input  wire logic [24:0]                    angle_noise_i,
  input  wire logic [24:0]                    bias_noise_i,
  input  wire logic [30:0]                    measure_noise_i,
  output abkf_pkg::data_t                     angle_o,
  output abkf_pkg::data_t                     bias_o
);
  import abkf_pkg::*;

  localparam int unsigned MagW  = DataWidth;          // magnitude, fits 2^(W-1)
  localparam int unsigned ProdW = 2 * MagW;
  localparam int unsigned NumW  = DataWidth + FracBits;

  // Filter state.
  data_t angle_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
  data_t rate_q, meas_q, k0_q, k1_q, err_q;

  // Registers widened to data; all fit below the data maximum.
  data_t dt, qa, qb, rn;
  assign dt = data_t'({{(DataWidth-25){1'b0}}, step_time_i});
  assign qa = data_t'({{(DataWidth-25){1'b0}}, angle_noise_i});
  assign qb = data_t'({{(DataWidth-25){1'b0}}, bias_noise_i});
  assign rn = data_t'({{(DataWidth-31){1'b0}}, measure_noise_i});

  // Operand selection for the shared multiplier.
  data_t op_a, op_b;
  always_comb begin
    op_a = k0_q;
    op_b = err_q;
    unique case (cmd_i.mul_sel)
      MulRateDt: begin op_a = sub_sat(rate_q, bias_q); op_b = dt; end
      MulD00Dt:  begin op_a = sub_sat(sub_sat(qa, pab_q), pba_q); op_b = dt; end
      MulD01Dt:  begin
        op_a = (pbb_q == DataMin) ? DataMax : -pbb_q;
        op_b = dt;
      end
      MulQbDt:   begin op_a = qb; op_b = dt; end
      MulK0Err:  begin op_a = k0_q; op_b = err_q; end
      MulK1Err:  begin op_a = k1_q; op_b = err_q; end
      MulK0Paa:  begin op_a = k0_q; op_b = paa_q; end
      MulK0Pab:  begin op_a = k0_q; op_b = pab_q; end
      MulK1Paa:  begin op_a = k1_q; op_b = paa_q; end
      MulK1Pab:  begin op_a = k1_q; op_b = pab_q; end
      default:   begin op_a = k0_q; op_b = err_q; end
    endcase
  end

  // Multiplier: magnitudes registered product, then round and saturate.
  logic [MagW-1:0]  mag_a, mag_b;
  logic [ProdW-1:0] prod_q;
  logic             prod_neg_q;
  assign mag_a = op_a[DataWidth-1] ? MagW'(-op_a) : MagW'(op_a);
  assign mag_b = op_b[DataWidth-1] ? MagW'(-op_b) : MagW'(op_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      prod_q     <= mag_a * mag_b;
      prod_neg_q <= op_a[DataWidth-1] ^ op_b[DataWidth-1];
    end
  end

  logic [ProdW:0]   prod_rnd;
  logic [ProdW-FracBits:0] prod_sh;
  data_t            mul_res;
  assign prod_rnd = {1'b0, prod_q} + ((ProdW+1)'(1) << (FracBits - 1));
  assign prod_sh  = prod_rnd[ProdW:FracBits];
  always_comb begin
    if (prod_neg_q) begin
      if (prod_sh > (ProdW-FracBits+1)'(DataMin[DataWidth-1:0] & {1'b1, {(DataWidth-1){1'b0}}}))
        mul_res = DataMin;
      else
        mul_res = data_t'(-prod_sh[DataWidth-1:0]);
    end else begin
      if (prod_sh > (ProdW-FracBits+1)'(DataMax))
        mul_res = DataMax;
      else
        mul_res = data_t'(prod_sh[DataWidth-1:0]);
    end
  end

  // Denominator and divider, one quotient bit a cycle.
  data_t e_val;
  assign e_val = add_sat(rn, paa_q);

  logic [MagW-1:0]    div_den_q;
  logic [NumW-1:0]    div_num_q;
  logic [MagW:0]      div_rem_q;
  logic [DataWidth:0] div_quo_q;
  logic               div_neg_q, div_zero_q, div_busy_q;
  logic [DivCntW-1:0] div_cnt_q;

  data_t div_numer;
  assign div_numer = cmd_i.div_num_ba ? pba_q : paa_q;

  logic [MagW+1:0] rem_sh;
  logic [MagW+1:0] rem_sub;
  logic [DataWidth+1:0] quo_sh;
  logic [DataWidth:0] quo_nx;
  assign rem_sh  = {div_rem_q, div_num_q[NumW-1]};
  assign rem_sub = rem_sh - {2'b00, div_den_q};
  assign quo_sh  = {div_quo_q, ~rem_sub[MagW+1]};
  // Quotient is held at 2^W, which is reached only once and stays.
  assign quo_nx  = (quo_sh > (DataWidth+2)'({1'b1, {DataWidth{1'b0}}})) ?
                   {1'b1, {DataWidth{1'b0}}} : quo_sh[DataWidth:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DivCntW'(DivSteps);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - 1'b1;
      if (div_cnt_q == DivCntW'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_den_q  <= e_val[DataWidth-1] ? MagW'(-e_val) : MagW'(e_val);
      div_num_q  <= {(div_numer[DataWidth-1] ? MagW'(-div_numer) : MagW'(div_numer)),
                     {FracBits{1'b0}}};
      div_rem_q  <= '0;
      div_quo_q  <= '0;
      div_neg_q  <= div_numer[DataWidth-1] ^ e_val[DataWidth-1];
      div_zero_q <= (e_val == '0);
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[NumW-2:0], 1'b0};
      div_rem_q <= rem_sub[MagW+1] ? rem_sh[MagW:0] : rem_sub[MagW:0];
      div_quo_q <= quo_nx;
    end
  end

  assign stat_o.div_done = !div_busy_q && !cmd_i.div_start;

  data_t div_res;
  always_comb begin
    if (div_zero_q) begin
      div_res = '0;
    end else if (div_neg_q) begin
      if (div_quo_q > {1'b0, 1'b1, {(DataWidth-1){1'b0}}}) div_res = DataMin;
      else div_res = data_t'(-div_quo_q[DataWidth-1:0]);
    end else begin
      if (div_quo_q > {1'b0, DataMax}) div_res = DataMax;
      else div_res = data_t'(div_quo_q[DataWidth-1:0]);
    end
  end

  // State updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      paa_q   <= data_t'(1) <<< FracBits;
      pab_q   <= '0;
      pba_q   <= '0;
      pbb_q   <= data_t'(1) <<< FracBits;
    end else begin
      if (cmd_i.wr_angle_pred) angle_q <= add_sat(angle_q, mul_res);
      if (cmd_i.wr_paa_pred)   paa_q   <= add_sat(paa_q, mul_res);
      if (cmd_i.wr_pab_pred) begin
        pab_q <= add_sat(pab_q, mul_res);
        pba_q <= add_sat(pba_q, mul_res);
      end
      if (cmd_i.wr_pbb_pred)   pbb_q   <= add_sat(pbb_q, mul_res);
      if (cmd_i.wr_angle_cor)  angle_q <= add_sat(angle_q, mul_res);
      if (cmd_i.wr_bias_cor)   bias_q  <= add_sat(bias_q, mul_res);
      if (cmd_i.wr_paa_cor)    paa_q   <= sub_sat(paa_q, mul_res);
      if (cmd_i.wr_pab_cor)    pab_q   <= sub_sat(pab_q, mul_res);
      if (cmd_i.wr_pba_cor)    pba_q   <= sub_sat(pba_q, mul_res);
      if (cmd_i.wr_pbb_cor)    pbb_q   <= sub_sat(pbb_q, mul_res);
    end
  end

  // Inputs, gains and innovation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rate_q <= rate_sample_i;
      meas_q <= angle_measure_i;
    end
    if (cmd_i.wr_k0) begin
      k0_q  <= div_res;
      err_q <= sub_sat(meas_q, angle_q);
    end
    if (cmd_i.wr_k1) k1_q <= div_res;
  end

  assign angle_o = angle_q;
  assign bias_o  = bias_q;

endmodule
`default_nettype wire

// ===== design/abkf_ctrl.sv =====
`default_nettype none
module abkf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output abkf_pkg::cmd_t       cmd_o,
  input  wire abkf_pkg::stat_t stat_i,
  output logic                 busy_o
);
  import abkf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StPredA;
      StPredA:  state_d = StPredAW;
      StPredAW: state_d = StPredP0;
      StPredP0: state_d = StPredP1;
      StPredP1: state_d = StPredP2;
      StPredP2: state_d = StDiv0Go;
      StDiv0Go: state_d = StDiv0;
      StDiv0:   if (stat_i.div_done) state_d = StDiv1Go;
      StDiv1Go: state_d = StDiv1;
      StDiv1:   if (stat_i.div_done) state_d = StCorA;
      StCorA:   state_d = StCorAW;
      StCorAW:  state_d = StCorB;
      StCorB:   state_d = StCorBW;
      StCorBW:  state_d = StCov0;
      StCov0:   state_d = StCov0W;
      StCov0W:  state_d = StCov1;
      StCov1:   state_d = StCov1W;
      StCov1W:  state_d = StCov2;
      StCov2:   state_d = StCov2W;
      StCov2W:  state_d = StCov3;
      StCov3:   state_d = StCov3W;
      StCov3W:  state_d = StOut;
      StOut:    if (!out_stall_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Outputs. Products of the covariance correction are all taken from the
  // old cov_aa and cov_ab before either is written back.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MulRateDt;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    busy_o        = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o    = 1'b0;
        busy_o        = 1'b0;
        cmd_o.load_in = 1'b1;
      end
      StPredA:  begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulRateDt; end
      StPredAW: begin
        cmd_o.wr_angle_pred = 1'b1;
        cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulD00Dt;
      end
      StPredP0: begin
        cmd_o.wr_paa_pred = 1'b1;
        cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulD01Dt;
      end
      StPredP1: begin
        cmd_o.wr_pab_pred = 1'b1;
        cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulQbDt;
      end
      StPredP2: cmd_o.wr_pbb_pred = 1'b1;
      StDiv0Go: cmd_o.div_start = 1'b1;
      StDiv0:   if (stat_i.div_done) cmd_o.wr_k0 = 1'b1;
      StDiv1Go: begin cmd_o.div_start = 1'b1; cmd_o.div_num_ba = 1'b1; end
      StDiv1:   if (stat_i.div_done) cmd_o.wr_k1 = 1'b1;
      StCorA:   begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK0Err; end
      StCorAW:  begin
        cmd_o.wr_angle_cor = 1'b1;
        cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK1Err;
      end
      StCorB:   cmd_o.wr_bias_cor = 1'b1;
      StCorBW:  begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK1Paa; end
      StCov0:   cmd_o.wr_pba_cor = 1'b1;
      StCov0W:  begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK1Pab; end
      StCov1:   cmd_o.wr_pbb_cor = 1'b1;
      StCov1W:  begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK0Pab; end
      StCov2:   cmd_o.wr_pab_cor = 1'b1;
      StCov2W:  begin cmd_o.mul_go = 1'b1; cmd_o.mul_sel = MulK0Paa; end
      StCov3:   cmd_o.wr_paa_cor = 1'b1;
      StCov3W:  ;
      StOut:    out_valid_o = 1'b1;
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/angle_bias_kalman_filter.sv =====
`default_nettype none
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid_i/in_stall_o | rate_sample_i, angle_measure_i
// out      | output    | out_valid_o/out_stall_i | angle_estimate_o, bias_estimate_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item's processing time is set by the two gain divisions, each run
// on the one-bit-per-cycle divider, plus a shared multiplier used
// ten times. Reset loads the default registers and the initial covariance.
// The result is held until out_stall_i is low; no new item is taken meanwhile.
module angle_bias_kalman_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] rate_sample_i,
  input  wire logic signed [31:0] angle_measure_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      angle_estimate_o,
  output logic signed [31:0]      bias_estimate_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import abkf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  logic [24:0] step_time_q, angle_noise_q, bias_noise_q;
  logic [30:0] measure_noise_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q     <= 25'd83886;
      angle_noise_q   <= 25'd16777;
      bias_noise_q    <= 25'd50331;
      measure_noise_q <= 31'd8388608;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegStepTime:     step_time_q     <= cfg_data_i[24:0];
        RegAngleNoise:   angle_noise_q   <= cfg_data_i[24:0];
        RegBiasNoise:    bias_noise_q    <= cfg_data_i[24:0];
        RegMeasureNoise: measure_noise_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  abkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .busy_o      (busy)
  );

  data_t angle_w, bias_w;

  abkf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rate_sample_i   (rate_sample_i),
    .angle_measure_i (angle_measure_i),
    .step_time_i     (step_time_q),
    .angle_noise_i   (angle_noise_q),
    .bias_noise_i    (bias_noise_q),
    .measure_noise_i (measure_noise_q),
    .angle_o         (angle_w),
    .bias_o          (bias_w)
  );

  // Estimates are stable from the end of the correction until the next item.
  assign angle_estimate_o = busy ? angle_w : angle_w;
  assign bias_estimate_o  = bias_w;

endmodule
`default_nettype wire
